// File: rtl/fpi_pkg.sv
// fpi_pkg: shared types, register indexes and fixed-point helpers
// for the flux polynomial and integral block and its checker.
// No dependencies.
package fpi_pkg;

    localparam int DATA_W        = 32;
    localparam int NUM_COEFS     = 5;
    localparam int TERMS_W       = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int MAX_TERMS_DEF = 4;
    localparam int FRAC_BITS_DEF = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_4     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_TERMS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEL_PSI    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_VALUE = 3'd7;

    typedef logic signed [DATA_W-1:0]   fx_t;
    typedef logic signed [2*DATA_W-1:0] wide_t;

    typedef struct packed {
        logic ovf;
        fx_t  val;
    } sat_t;

    // clamp to the signed data range, flag when clamped
    function automatic sat_t sat32(wide_t v);
        sat_t  r;
        wide_t hi;
        wide_t lo;
        hi = {{(DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
        begin
            r.ovf = 1'b1;
            r.val = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (v < lo)
        begin
            r.ovf = 1'b1;
            r.val = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            r.ovf = 1'b0;
            r.val = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // full product rounded to frac fraction bits, ties toward plus infinity
    function automatic wide_t fx_mul(fx_t a, fx_t b, int frac);
        wide_t p;
        p = wide_t'(a) * wide_t'(b);
        return (p + (wide_t'(1) <<< (frac - 1))) >>> frac;
    endfunction

    function automatic sat_t one_minus(fx_t v, int frac);
        return sat32((wide_t'(1) <<< frac) - wide_t'(v));
    endfunction

endpackage

// File: rtl/flux_polynomial_and_integral_top.sv
// flux_polynomial_and_integral_top: seven-stage pipeline evaluating a flux
// polynomial (Horner form) or its integral form in signed fixed point.
// Depends on fpi_pkg.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   coefficients, num_terms, del_psi and edge_value; cfg_ready is always
//   high. Write only while no request is in flight.
//   s_t* carries one request: s_tdata = x_coord, s_tuser = func
//   (0 function value, 1 integral form).
//   m_t* returns one result per request: m_tdata = value,
//   m_tuser = overflow (some clamp happened on the way).
// Throughput: one request per cycle while the output is not stalled.
// Stages: results reach m_tvalid through seven register stages (the first loaded at
//   acceptance): three dependent multiplies of the power/Horner chain, the
//   function sum with the last term products, the term sum, the del_psi
//   product and the final subtract.
// Reset clears the configuration registers and the stage valid bits, which
//   empties the pipeline.
// When the receiver stalls, filled stages hold; empty stages ahead of the
//   stall keep filling, so s_tready drops only once all seven stages hold
//   a result or a request.
module flux_polynomial_and_integral_top
    import fpi_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,   // [31:0] x_coord
    input  logic [0:0]           s_tuser,   // [0] func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,   // [31:0] value
    output logic [0:0]           m_tuser    // [0] overflow
);

    localparam int NUM_STAGES = 7;
    localparam fx_t RECIP_1 = fx_t'(((1 << FRAC_BITS) + 0) / 1);
    localparam fx_t RECIP_2 = fx_t'(((1 << FRAC_BITS) + 1) / 2);
    localparam fx_t RECIP_3 = fx_t'(((1 << FRAC_BITS) + 1) / 3);
    localparam fx_t RECIP_4 = fx_t'(((1 << FRAC_BITS) + 2) / 4);

    // configuration registers
    fx_t                coef_reg [NUM_COEFS];
    logic [TERMS_W-1:0] num_terms_reg;
    fx_t                del_psi_reg;
    fx_t                edge_value_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEFS; i++)
            begin
                coef_reg[i] <= '0;
            end
            num_terms_reg  <= '0;
            del_psi_reg    <= '0;
            edge_value_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_COEF_0:     coef_reg[0]    <= cfg_data;
                CFG_COEF_1:     coef_reg[1]    <= cfg_data;
                CFG_COEF_2:     coef_reg[2]    <= cfg_data;
                CFG_COEF_3:     coef_reg[3]    <= cfg_data;
                CFG_COEF_4:     coef_reg[4]    <= cfg_data;
                CFG_NUM_TERMS:  num_terms_reg  <= cfg_data[TERMS_W-1:0];
                CFG_DEL_PSI:    del_psi_reg    <= cfg_data;
                CFG_EDGE_VALUE: edge_value_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    logic [TERMS_W-1:0] n_eff;
    assign n_eff = (num_terms_reg > TERMS_W'(MAX_TERMS)) ? TERMS_W'(MAX_TERMS)
                                                         : num_terms_reg;

    // coefficient times reciprocal, refreshed every cycle from the registers
    sat_t d1_sat, d2_sat, d3_sat, d4_sat;
    fx_t  d1_reg, d2_reg, d3_reg, d4_reg;
    logic [4:1] d_ovf_reg;

    assign d1_sat = sat32(fx_mul(coef_reg[1], RECIP_1, FRAC_BITS));
    assign d2_sat = sat32(fx_mul(coef_reg[2], RECIP_2, FRAC_BITS));
    assign d3_sat = sat32(fx_mul(coef_reg[3], RECIP_3, FRAC_BITS));
    assign d4_sat = sat32(fx_mul(coef_reg[4], RECIP_4, FRAC_BITS));

    always_ff @(posedge clk)
    begin
        d1_reg    <= d1_sat.val;
        d2_reg    <= d2_sat.val;
        d3_reg    <= d3_sat.val;
        d4_reg    <= d4_sat.val;
        d_ovf_reg <= {d4_sat.ovf, d3_sat.ovf, d2_sat.ovf, d1_sat.ovf};
    end

    // stage handshake: a stage loads when it is empty or its successor loads
    logic [NUM_STAGES:1]   valid_reg;
    logic [NUM_STAGES-1:0] valid_in;
    logic [NUM_STAGES+1:1] rdy;

    always_comb
    begin
        rdy[NUM_STAGES+1] = m_tready;
        for (int k = NUM_STAGES; k >= 1; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign valid_in = {valid_reg[NUM_STAGES-1:1], s_tvalid};
    assign s_tready = rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= NUM_STAGES; k++)
            begin
                if (rdy[k])
                begin
                    valid_reg[k] <= valid_in[k-1];
                end
            end
        end
    end

    // stage 1: first Horner step, 1-x, x^2
    fx_t  x_in;
    logic func_in;
    fx_t  h_start;
    sat_t h1_sat, omx_sat, pw2_sat;
    fx_t  p1_next;
    logic ovf1_next;

    fx_t  s1_x_reg, s1_p_reg, s1_omx_reg, s1_pw2_reg;
    logic s1_func_reg, s1_ovf_reg;

    assign x_in    = s_tdata;
    assign func_in = s_tuser[0];
    assign h_start = (n_eff == '0) ? fx_t'(0) : coef_reg[n_eff];
    assign h1_sat  = sat32(fx_mul(h_start, x_in, FRAC_BITS) + wide_t'(coef_reg[3]));
    assign omx_sat = one_minus(x_in, FRAC_BITS);
    assign pw2_sat = sat32(fx_mul(x_in, x_in, FRAC_BITS));
    assign p1_next = (n_eff > 3'd3) ? h1_sat.val : h_start;
    assign ovf1_next = func_in ? (omx_sat.ovf || (pw2_sat.ovf && n_eff >= 3'd2))
                               : (h1_sat.ovf && n_eff > 3'd3);

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            s1_x_reg    <= x_in;
            s1_func_reg <= func_in;
            s1_ovf_reg  <= ovf1_next;
            s1_p_reg    <= p1_next;
            s1_omx_reg  <= omx_sat.val;
            s1_pw2_reg  <= pw2_sat.val;
        end
    end

    // stage 2: second Horner step, x^3, c0*(1-x), first integral term
    sat_t  h2_sat, pw3_sat, om2_sat;
    logic  ovf2_next;

    fx_t   s2_x_reg, s2_p_reg, s2_pw3_reg, s2_om2_reg;
    wide_t s2_a0_reg, s2_t1_reg;
    logic  s2_func_reg, s2_ovf_reg;

    assign h2_sat  = sat32(fx_mul(s1_p_reg, s1_x_reg, FRAC_BITS) + wide_t'(coef_reg[2]));
    assign pw3_sat = sat32(fx_mul(s1_pw2_reg, s1_x_reg, FRAC_BITS));
    assign om2_sat = one_minus(s1_pw2_reg, FRAC_BITS);
    assign ovf2_next = s1_ovf_reg ||
        (s1_func_reg ? ((pw3_sat.ovf && n_eff >= 3'd3) ||
                        (om2_sat.ovf && n_eff >= 3'd2) ||
                        (d_ovf_reg[1] && n_eff >= 3'd1))
                     : (h2_sat.ovf && n_eff > 3'd2));

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            s2_x_reg    <= s1_x_reg;
            s2_func_reg <= s1_func_reg;
            s2_ovf_reg  <= ovf2_next;
            s2_p_reg    <= (n_eff > 3'd2) ? h2_sat.val : s1_p_reg;
            s2_pw3_reg  <= pw3_sat.val;
            s2_om2_reg  <= om2_sat.val;
            s2_a0_reg   <= fx_mul(coef_reg[0], s1_omx_reg, FRAC_BITS);
            s2_t1_reg   <= fx_mul(d1_reg, s1_omx_reg, FRAC_BITS);
        end
    end

    // stage 3: last Horner step, x^4, second integral term
    sat_t  h3_sat, pw4_sat, om3_sat;
    logic  ovf3_next;

    fx_t   s3_p_reg, s3_pw4_reg, s3_om3_reg;
    wide_t s3_acc_reg, s3_t2_reg;
    logic  s3_func_reg, s3_ovf_reg;

    assign h3_sat  = sat32(fx_mul(s2_p_reg, s2_x_reg, FRAC_BITS) + wide_t'(coef_reg[1]));
    assign pw4_sat = sat32(fx_mul(s2_pw3_reg, s2_x_reg, FRAC_BITS));
    assign om3_sat = one_minus(s2_pw3_reg, FRAC_BITS);
    assign ovf3_next = s2_ovf_reg ||
        (s2_func_reg ? ((pw4_sat.ovf && n_eff >= 3'd4) ||
                        (om3_sat.ovf && n_eff >= 3'd3) ||
                        (d_ovf_reg[2] && n_eff >= 3'd2))
                     : (h3_sat.ovf && n_eff > 3'd1));

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            s3_func_reg <= s2_func_reg;
            s3_ovf_reg  <= ovf3_next;
            s3_p_reg    <= (n_eff > 3'd1) ? h3_sat.val : s2_p_reg;
            s3_pw4_reg  <= pw4_sat.val;
            s3_om3_reg  <= om3_sat.val;
            s3_acc_reg  <= s2_a0_reg + ((n_eff >= 3'd1) ? s2_t1_reg : wide_t'(0));
            s3_t2_reg   <= fx_mul(d2_reg, s2_om2_reg, FRAC_BITS);
        end
    end

    // stage 4: function result, third and fourth integral terms
    sat_t  r0_sat, om4_sat;
    logic  ovf4_next;

    fx_t   s4_val_reg;
    wide_t s4_acc_reg, s4_t3_reg, s4_t4_reg;
    logic  s4_func_reg, s4_ovf_reg;

    assign r0_sat  = sat32(wide_t'(coef_reg[0]) + wide_t'(s3_p_reg));
    assign om4_sat = one_minus(s3_pw4_reg, FRAC_BITS);
    assign ovf4_next = s3_ovf_reg ||
        (s3_func_reg ? ((om4_sat.ovf && n_eff >= 3'd4) ||
                        (d_ovf_reg[3] && n_eff >= 3'd3) ||
                        (d_ovf_reg[4] && n_eff >= 3'd4))
                     : r0_sat.ovf);

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            s4_func_reg <= s3_func_reg;
            s4_ovf_reg  <= ovf4_next;
            s4_val_reg  <= r0_sat.val;
            s4_acc_reg  <= s3_acc_reg + ((n_eff >= 3'd2) ? s3_t2_reg : wide_t'(0));
            s4_t3_reg   <= fx_mul(d3_reg, s3_om3_reg, FRAC_BITS);
            s4_t4_reg   <= fx_mul(d4_reg, om4_sat.val, FRAC_BITS);
        end
    end

    // stage 5: close the bracketed sum
    wide_t acc_sum;
    sat_t  s_sat;
    fx_t   s5_val_reg;
    logic  s5_func_reg, s5_ovf_reg;

    assign acc_sum = s4_acc_reg
                   + ((n_eff >= 3'd3) ? s4_t3_reg : wide_t'(0))
                   + ((n_eff >= 3'd4) ? s4_t4_reg : wide_t'(0));
    assign s_sat = sat32(acc_sum);

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            s5_func_reg <= s4_func_reg;
            s5_ovf_reg  <= s4_ovf_reg || (s4_func_reg && s_sat.ovf);
            s5_val_reg  <= s4_func_reg ? s_sat.val : s4_val_reg;
        end
    end

    // stage 6: scale the integral sum by del_psi; function values pass through
    sat_t m_sat;
    fx_t  s6_val_reg;
    logic s6_func_reg, s6_ovf_reg;

    assign m_sat = sat32(fx_mul(del_psi_reg, s5_val_reg, FRAC_BITS));

    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            s6_func_reg <= s5_func_reg;
            s6_ovf_reg  <= s5_ovf_reg || (s5_func_reg && m_sat.ovf);
            s6_val_reg  <= s5_func_reg ? m_sat.val : s5_val_reg;
        end
    end

    // stage 7: subtract the integral from the edge value, output register
    sat_t r1_sat;
    fx_t  s7_val_reg;
    logic s7_ovf_reg;

    assign r1_sat = sat32(wide_t'(edge_value_reg) - wide_t'(s6_val_reg));

    always_ff @(posedge clk)
    begin
        if (rdy[7])
        begin
            s7_ovf_reg <= s6_ovf_reg || (s6_func_reg && r1_sat.ovf);
            s7_val_reg <= s6_func_reg ? r1_sat.val : s6_val_reg;
        end
    end

    assign m_tvalid   = valid_reg[NUM_STAGES];
    assign m_tdata    = s7_val_reg;
    assign m_tuser[0] = s7_ovf_reg;

endmodule

// File: rtl/fpi_checker.sv
// fpi_checker: port-level assertions for flux_polynomial_and_integral_top,
// bound to the top level at the end of this file.
// Depends on fpi_pkg.
module fpi_checker
    import fpi_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic [0:0]        m_tuser
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // input backpressure only comes from a full, stalled output
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("s_tready low without a stalled output");

    // configuration writes are never held off
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration request not taken");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result shown during reset");

endmodule

bind flux_polynomial_and_integral_top fpi_checker u_fpi_checker (.*);
